// File: src/srdc_pkg.sv
package srdc_pkg;

    localparam int POS_W     = 16;
    localparam int TIME_W    = 32;
    localparam int DIST_W    = 34;
    localparam int CFG_DATA_W = 34;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_MERGE_DIST_SQ = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COOLDOWN_MS   = 1'd1;

    localparam logic [DIST_W-1:0] MERGE_DIST_SQ_RST = 34'd65536;
    localparam logic [TIME_W-1:0] COOLDOWN_MS_RST   = 32'd30000;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [TIME_W-1:0]       now_ms;
    } in_word_t;

    typedef struct packed {
        logic signed [POS_W-1:0] out_x;
        logic signed [POS_W-1:0] out_y;
        logic signed [POS_W-1:0] out_z;
        logic                    re_report;
        logic                    not_stored;
    } out_word_t;

endpackage

// File: src/srdc_ram.sv
module srdc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/spatial_report_dedup_cooldown_top.sv
// Report de-duplication with cooldown.
// Input channel (in_valid / in_stall / in_word): one detected position and a
// millisecond timestamp per word. Output channel (out_valid / out_stall /
// out_word): zero or one report per input word, in input order.
// Configuration (cfg_we / cfg_index / cfg_data): merge radius squared and
// cooldown; write only while the block is idle.
// Each input word scans the stored locations one entry a cycle through the
// position and time RAMs, with a two-stage distance pipeline behind the read.
// A word with no match is compared against all n stored locations, n being
// at most TABLE_DEPTH; with an empty table the scan is skipped. It then passes
// the decide and emit states into the output register, and the next word is
// taken once the block is back in idle. The scan stops at the first match; a
// matched word inside the cooldown is suppressed in the decide state and frees
// the input without a report. in_stall stays high during that work.
// The output register holds one finished report; the next input word is taken
// while that report waits on out_stall, and its own report waits until the
// register frees up.
// Reset empties the table (no clearing pass) and restores the default merge
// radius squared (65536) and cooldown (30000 ms).
module spatial_report_dedup_cooldown_top #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  srdc_pkg::in_word_t                   in_word,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output srdc_pkg::out_word_t                  out_word,
    input  logic                                 cfg_we,
    input  logic [srdc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [srdc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam int PW = srdc_pkg::POS_W;
    localparam int TW = srdc_pkg::TIME_W;
    localparam int DW = srdc_pkg::DIST_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       n_reg, n_next;
    logic [CW-1:0]       issue_reg, issue_next;
    logic                rd_valid_reg, rd_valid_next;
    logic [AW-1:0]       rd_idx_reg, rd_idx_next;
    logic                sq_valid_reg, sq_valid_next;
    logic [AW-1:0]       sq_idx_reg, sq_idx_next;
    logic [TW-1:0]       sq_time_reg, sq_time_next;
    logic [DW-1:0]       sqx_reg, sqx_next;
    logic [DW-1:0]       sqy_reg, sqy_next;
    logic                hit_reg, hit_next;
    logic [AW-1:0]       hit_idx_reg, hit_idx_next;
    logic [TW-1:0]       hit_time_reg, hit_time_next;
    logic [DW-1:0]       merge_reg, merge_next;
    logic [TW-1:0]       cool_reg, cool_next;
    logic                out_valid_reg, out_valid_next;
    srdc_pkg::in_word_t  item_reg, item_next;
    srdc_pkg::out_word_t res_reg, res_next;
    srdc_pkg::out_word_t out_word_reg, out_word_next;

    logic                pos_we, time_we;
    logic [AW-1:0]       pos_waddr, time_waddr;
    logic [2*PW-1:0]     pos_wdata, pos_rdata;
    logic [TW-1:0]       time_wdata, time_rdata;
    logic [AW-1:0]       raddr;

    logic signed [PW:0]  dx, dy;
    logic [DW-1:0]       dist_sq;
    logic [TW-1:0]       elapsed;
    logic                accept;
    logic                last_idx;

    srdc_ram #(.WIDTH(2 * PW), .DEPTH(TABLE_DEPTH)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (raddr),
        .rdata (pos_rdata)
    );

    srdc_ram #(.WIDTH(TW), .DEPTH(TABLE_DEPTH)) u_time_ram (
        .clk   (clk),
        .we    (time_we),
        .waddr (time_waddr),
        .wdata (time_wdata),
        .raddr (raddr),
        .rdata (time_rdata)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign raddr     = issue_reg[AW-1:0];

    assign dx       = {pos_rdata[2*PW-1], pos_rdata[2*PW-1:PW]} -
                      {item_reg.pos_x[PW-1], item_reg.pos_x};
    assign dy       = {pos_rdata[PW-1], pos_rdata[PW-1:0]} -
                      {item_reg.pos_y[PW-1], item_reg.pos_y};
    assign dist_sq  = sqx_reg + sqy_reg;
    assign elapsed  = item_reg.now_ms - hit_time_reg;
    assign last_idx = ((CW'(sq_idx_reg) + CW'(1)) == n_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        n_next         = n_reg;
        issue_next     = issue_reg;
        rd_valid_next  = 1'b0;
        rd_idx_next    = issue_reg[AW-1:0];
        sq_valid_next  = 1'b0;
        sq_idx_next    = rd_idx_reg;
        sq_time_next   = time_rdata;
        sqx_next       = dx * dx;
        sqy_next       = dy * dy;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_time_next  = hit_time_reg;
        merge_next     = merge_reg;
        cool_next      = cool_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_word_next  = out_word_reg;
        pos_we         = 1'b0;
        time_we        = 1'b0;
        pos_waddr      = n_reg[AW-1:0];
        time_waddr     = n_reg[AW-1:0];
        pos_wdata      = {item_reg.pos_x, item_reg.pos_y};
        time_wdata     = item_reg.now_ms;

        if (cfg_we)
        begin
            unique case (cfg_index)
                srdc_pkg::CFG_MERGE_DIST_SQ: merge_next = cfg_data[DW-1:0];
                srdc_pkg::CFG_COOLDOWN_MS:   cool_next  = cfg_data[TW-1:0];
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next  = in_word;
                    n_next     = count_reg;
                    issue_next = '0;
                    hit_next   = 1'b0;
                    state_next = (count_reg == '0) ? ST_DECIDE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // advance the read pointer and the distance pipeline
                if (issue_reg < n_reg)
                begin
                    rd_valid_next = 1'b1;
                    issue_next    = issue_reg + CW'(1);
                end
                sq_valid_next = rd_valid_reg;
                if (sq_valid_reg)
                begin
                    if (dist_sq < merge_reg)
                    begin
                        hit_next      = 1'b1;
                        hit_idx_next  = sq_idx_reg;
                        hit_time_next = sq_time_reg;
                    end
                    if (dist_sq < merge_reg || last_idx)
                    begin
                        // drop reads still in flight
                        rd_valid_next = 1'b0;
                        sq_valid_next = 1'b0;
                        state_next    = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE:
            begin
                res_next.out_x      = item_reg.pos_x;
                res_next.out_y      = item_reg.pos_y;
                res_next.out_z      = item_reg.pos_z;
                res_next.re_report  = hit_reg;
                res_next.not_stored = 1'b0;
                state_next          = ST_EMIT;
                if (hit_reg)
                begin
                    if (elapsed < cool_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        time_we    = 1'b1;
                        time_waddr = hit_idx_reg;
                    end
                end
                else if (n_reg < DEPTH_C)
                begin
                    pos_we     = 1'b1;
                    time_we    = 1'b1;
                    count_next = n_reg + CW'(1);
                end
                else
                begin
                    res_next.not_stored = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            sq_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            merge_reg     <= srdc_pkg::MERGE_DIST_SQ_RST;
            cool_reg      <= srdc_pkg::COOLDOWN_MS_RST;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_valid_reg  <= rd_valid_next;
            sq_valid_reg  <= sq_valid_next;
            out_valid_reg <= out_valid_next;
            merge_reg     <= merge_next;
            cool_reg      <= cool_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        issue_reg    <= issue_next;
        rd_idx_reg   <= rd_idx_next;
        sq_idx_reg   <= sq_idx_next;
        sq_time_reg  <= sq_time_next;
        sqx_reg      <= sqx_next;
        sqy_reg      <= sqy_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        hit_time_reg <= hit_time_next;
        item_reg     <= item_next;
        res_reg      <= res_next;
        out_word_reg <= out_word_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count above table depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + CW'(1)))
        else $error("entry count moved by more than one");

    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (issue_reg <= n_reg))
        else $error("scan read pointer past stored entries");

    a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DECIDE) && hit_reg) |-> (CW'(hit_idx_reg) < n_reg))
        else $error("match index outside stored entries");

    a_pipe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_SCAN) |=> !sq_valid_reg)
        else $error("distance pipeline active outside scan");
`endif

endmodule
